### rtl/vsfp_pkg.sv
package vsfp_pkg;

  // frame delimiters and field codes
  localparam logic [7:0] HDR0        = 8'h53;
  localparam logic [7:0] HDR1        = 8'h59;
  localparam logic [7:0] TAIL0       = 8'h54;
  localparam logic [7:0] TAIL1       = 8'h43;
  localparam logic [7:0] CTRL_HEART  = 8'h85;
  localparam logic [7:0] CTRL_BREATH = 8'h81;
  localparam logic [7:0] CMD_RATE    = 8'h02;
  localparam logic [7:0] CMD_STATE   = 8'h01;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_LENGTH   = 3'd1,
    ERR_CHECKSUM = 3'd2,
    ERR_TAIL0    = 3'd3,
    ERR_TAIL1    = 3'd4
  } err_code_t;

  typedef enum logic [9:0] {
    PH_HDR0  = 10'b00_0000_0001,
    PH_HDR1  = 10'b00_0000_0010,
    PH_CTRL  = 10'b00_0000_0100,
    PH_CMD   = 10'b00_0000_1000,
    PH_LENH  = 10'b00_0001_0000,
    PH_LENL  = 10'b00_0010_0000,
    PH_DATA  = 10'b00_0100_0000,
    PH_SUM   = 10'b00_1000_0000,
    PH_TAIL0 = 10'b01_0000_0000,
    PH_TAIL1 = 10'b10_0000_0000
  } phase_t;

  typedef struct packed {
    logic        frame_ok;
    err_code_t   error_code;
    logic [7:0]  frame_control;
    logic [7:0]  frame_command;
    logic [7:0]  pulse_rate;
    logic        pulse_rate_valid;
    logic [7:0]  resp_rate;
    logic        resp_rate_valid;
    logic [7:0]  resp_status;
    logic        resp_status_valid;
    logic [31:0] good_frames;
    logic [31:0] bad_frames;
  } result_t;

endpackage

### rtl/vsfp_in_stage.sv
module vsfp_in_stage (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  input  logic       advance,
  output logic       stage_valid,
  output logic [7:0] stage_byte
);

  assign in_ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_byte <= rx_byte;
    end
  end

endmodule

### rtl/vsfp_parse_core.sv
module vsfp_parse_core #(
  parameter int MAX_PAYLOAD = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        rx_byte,
  output vsfp_pkg::result_t res_next
);

  localparam int POS_W = $clog2(MAX_PAYLOAD + 1);
  localparam logic [15:0] MAX_LEN = 16'(MAX_PAYLOAD);

  vsfp_pkg::phase_t phase, phase_next;
  logic [7:0]       control_word, control_word_next;
  logic [7:0]       command_word, command_word_next;
  logic [15:0]      payload_length, payload_length_next;
  logic [POS_W-1:0] payload_position, payload_position_next;
  logic [7:0]       first_payload_byte, first_payload_byte_next;
  logic [7:0]       running_sum, running_sum_next;
  logic [31:0]      frame_counter, frame_counter_next;
  logic [31:0]      error_counter, error_counter_next;
  logic [7:0]       heart_value, heart_value_next;
  logic             heart_flag, heart_flag_next;
  logic [7:0]       breath_value, breath_value_next;
  logic             breath_flag, breath_flag_next;
  logic [7:0]       breath_mode, breath_mode_next;
  logic             breath_mode_flag, breath_mode_flag_next;

  logic                 ok;
  vsfp_pkg::err_code_t  err;
  logic [7:0]           sum_add;
  logic [15:0]          len_full;
  logic [POS_W-1:0]     pos_inc;

  assign sum_add  = running_sum + rx_byte;
  assign len_full = {payload_length[15:8], rx_byte};
  assign pos_inc  = payload_position + 1'b1;

  always_comb begin
    phase_next              = phase;
    control_word_next       = control_word;
    command_word_next       = command_word;
    payload_length_next     = payload_length;
    payload_position_next   = payload_position;
    first_payload_byte_next = first_payload_byte;
    running_sum_next        = running_sum;
    frame_counter_next      = frame_counter;
    error_counter_next      = error_counter;
    heart_value_next        = heart_value;
    heart_flag_next         = heart_flag;
    breath_value_next       = breath_value;
    breath_flag_next        = breath_flag;
    breath_mode_next        = breath_mode;
    breath_mode_flag_next   = breath_mode_flag;
    ok                      = 1'b0;
    err                     = vsfp_pkg::ERR_NONE;

    unique case (phase)
      vsfp_pkg::PH_HDR0: begin
        if (rx_byte == vsfp_pkg::HDR0) begin
          running_sum_next = rx_byte;
          phase_next       = vsfp_pkg::PH_HDR1;
        end
      end
      vsfp_pkg::PH_HDR1: begin
        if (rx_byte == vsfp_pkg::HDR1) begin
          running_sum_next = sum_add;
          phase_next       = vsfp_pkg::PH_CTRL;
        end else begin
          payload_length_next   = '0;
          payload_position_next = '0;
          if (rx_byte == vsfp_pkg::HDR0) begin
            // another sync byte re-arms the search
            running_sum_next = rx_byte;
            phase_next       = vsfp_pkg::PH_HDR1;
          end else begin
            running_sum_next = '0;
            phase_next       = vsfp_pkg::PH_HDR0;
          end
        end
      end
      vsfp_pkg::PH_CTRL: begin
        control_word_next = rx_byte;
        running_sum_next  = sum_add;
        phase_next        = vsfp_pkg::PH_CMD;
      end
      vsfp_pkg::PH_CMD: begin
        command_word_next = rx_byte;
        running_sum_next  = sum_add;
        phase_next        = vsfp_pkg::PH_LENH;
      end
      vsfp_pkg::PH_LENH: begin
        payload_length_next = {rx_byte, 8'h00};
        running_sum_next    = sum_add;
        phase_next          = vsfp_pkg::PH_LENL;
      end
      vsfp_pkg::PH_LENL: begin
        if (len_full > MAX_LEN) begin
          err                   = vsfp_pkg::ERR_LENGTH;
          error_counter_next    = error_counter + 32'd1;
          payload_length_next   = '0;
          payload_position_next = '0;
          running_sum_next      = '0;
          phase_next            = vsfp_pkg::PH_HDR0;
        end else begin
          payload_length_next   = len_full;
          payload_position_next = '0;
          running_sum_next      = sum_add;
          phase_next            = (len_full != 16'd0) ? vsfp_pkg::PH_DATA
                                                      : vsfp_pkg::PH_SUM;
        end
      end
      vsfp_pkg::PH_DATA: begin
        if (payload_position == '0) begin
          first_payload_byte_next = rx_byte;
        end
        payload_position_next = pos_inc;
        running_sum_next      = sum_add;
        if (16'(pos_inc) >= payload_length) begin
          phase_next = vsfp_pkg::PH_SUM;
        end
      end
      vsfp_pkg::PH_SUM: begin
        if (rx_byte == running_sum) begin
          phase_next = vsfp_pkg::PH_TAIL0;
        end else begin
          err                   = vsfp_pkg::ERR_CHECKSUM;
          error_counter_next    = error_counter + 32'd1;
          payload_length_next   = '0;
          payload_position_next = '0;
          running_sum_next      = '0;
          phase_next            = vsfp_pkg::PH_HDR0;
        end
      end
      vsfp_pkg::PH_TAIL0: begin
        if (rx_byte == vsfp_pkg::TAIL0) begin
          phase_next = vsfp_pkg::PH_TAIL1;
        end else begin
          err                   = vsfp_pkg::ERR_TAIL0;
          error_counter_next    = error_counter + 32'd1;
          payload_length_next   = '0;
          payload_position_next = '0;
          running_sum_next      = '0;
          phase_next            = vsfp_pkg::PH_HDR0;
        end
      end
      vsfp_pkg::PH_TAIL1: begin
        if (rx_byte == vsfp_pkg::TAIL1) begin
          ok                 = 1'b1;
          frame_counter_next = frame_counter + 32'd1;
          // single data byte frames with a matching control and command carry one of the tracked readings
          if (payload_length == 16'd1) begin
            priority if (control_word == vsfp_pkg::CTRL_HEART &&
                         command_word == vsfp_pkg::CMD_RATE) begin
              heart_value_next = first_payload_byte;
              heart_flag_next  = 1'b1;
            end else if (control_word == vsfp_pkg::CTRL_BREATH &&
                         command_word == vsfp_pkg::CMD_RATE) begin
              breath_value_next = first_payload_byte;
              breath_flag_next  = 1'b1;
            end else if (control_word == vsfp_pkg::CTRL_BREATH &&
                         command_word == vsfp_pkg::CMD_STATE) begin
              breath_mode_next      = first_payload_byte;
              breath_mode_flag_next = 1'b1;
            end else begin
            end
          end
        end else begin
          err                = vsfp_pkg::ERR_TAIL1;
          error_counter_next = error_counter + 32'd1;
        end
        payload_length_next   = '0;
        payload_position_next = '0;
        running_sum_next      = '0;
        phase_next            = vsfp_pkg::PH_HDR0;
      end
      default: begin
        payload_length_next   = '0;
        payload_position_next = '0;
        running_sum_next      = '0;
        phase_next            = vsfp_pkg::PH_HDR0;
      end
    endcase
  end

  always_comb begin
    res_next.frame_ok          = ok;
    res_next.error_code        = err;
    res_next.frame_control     = control_word_next;
    res_next.frame_command     = command_word_next;
    res_next.pulse_rate        = heart_value_next;
    res_next.pulse_rate_valid  = heart_flag_next;
    res_next.resp_rate         = breath_value_next;
    res_next.resp_rate_valid   = breath_flag_next;
    res_next.resp_status       = breath_mode_next;
    res_next.resp_status_valid = breath_mode_flag_next;
    res_next.good_frames       = frame_counter_next;
    res_next.bad_frames        = error_counter_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= vsfp_pkg::PH_HDR0;
      control_word       <= '0;
      command_word       <= '0;
      payload_length     <= '0;
      payload_position   <= '0;
      first_payload_byte <= '0;
      running_sum        <= '0;
      frame_counter      <= '0;
      error_counter      <= '0;
      heart_value        <= '0;
      heart_flag         <= 1'b0;
      breath_value       <= '0;
      breath_flag        <= 1'b0;
      breath_mode        <= '0;
      breath_mode_flag   <= 1'b0;
    end else if (step) begin
      phase              <= phase_next;
      control_word       <= control_word_next;
      command_word       <= command_word_next;
      payload_length     <= payload_length_next;
      payload_position   <= payload_position_next;
      first_payload_byte <= first_payload_byte_next;
      running_sum        <= running_sum_next;
      frame_counter      <= frame_counter_next;
      error_counter      <= error_counter_next;
      heart_value        <= heart_value_next;
      heart_flag         <= heart_flag_next;
      breath_value       <= breath_value_next;
      breath_flag        <= breath_flag_next;
      breath_mode        <= breath_mode_next;
      breath_mode_flag   <= breath_mode_flag_next;
    end
  end

  a_good_count_step: assert property (@(posedge clk) disable iff (rst)
    step && ok |=> frame_counter == $past(frame_counter) + 32'd1)
    else $error("good frame counter did not advance on a good frame");

  a_bad_count_step: assert property (@(posedge clk) disable iff (rst)
    step && err != vsfp_pkg::ERR_NONE |=> error_counter == $past(error_counter) + 32'd1)
    else $error("error counter did not advance on a frame error");

  a_data_within_length: assert property (@(posedge clk) disable iff (rst)
    phase == vsfp_pkg::PH_DATA |-> 16'(payload_position) < payload_length)
    else $error("data position ran past the frame length");

  a_heart_flag_sticky: assert property (@(posedge clk) disable iff (rst)
    !$fell(heart_flag))
    else $error("heart rate valid flag dropped without reset");

endmodule

### rtl/vital_sign_frame_parser_unit.sv
// vital-sign frame parser: one received serial byte per input word
//
// input channel: in_valid / in_ready with rx_byte. every accepted byte
// produces exactly one output word on out_valid / out_ready.
// frames are 0x53 0x59, control, command, 16-bit big-endian length, data,
// an 8-bit sum of all preceding bytes, then 0x54 0x43.
// output word: frame_ok pulses on the byte that closes a good frame,
// error_code flags length / checksum / tail errors on the byte that caused
// them; the remaining fields show the latched readings and the counters as
// they stand after that byte.
// path: an accepted byte waits in the input register, then the parse step
// feeds its word into the output register, which raises out_valid.
// throughput: one byte per cycle while out_ready stays high; the parse step
// is a single state update between the input register and output register.
// reset (rst, synchronous): parser back to header search, all readings,
// flags and counters cleared, both pipeline registers empty.
// receiver stall: the output register holds its word, the input register
// takes one byte more if empty, then in_ready drops until out_ready returns.
module vital_sign_frame_parser_unit #(
  parameter int MAX_PAYLOAD = 64
) (
  input  logic        clk,
  input  logic        rst,
  // byte input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        frame_ok,
  output logic [2:0]  error_code,
  output logic [7:0]  frame_control,
  output logic [7:0]  frame_command,
  output logic [7:0]  pulse_rate,
  output logic        pulse_rate_valid,
  output logic [7:0]  resp_rate,
  output logic        resp_rate_valid,
  output logic [7:0]  resp_status,
  output logic        resp_status_valid,
  output logic [31:0] good_frames,
  output logic [31:0] bad_frames
);

  logic              stage_valid;
  logic [7:0]        stage_byte;
  logic              advance;
  vsfp_pkg::result_t res_next;
  vsfp_pkg::result_t res;

  // the staged byte moves on whenever the output register is free or draining
  assign advance = stage_valid && (!out_valid || out_ready);

  vsfp_in_stage u_in_stage (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .rx_byte     (rx_byte),
    .advance     (advance),
    .stage_valid (stage_valid),
    .stage_byte  (stage_byte)
  );

  vsfp_parse_core #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_parse_core (
    .clk      (clk),
    .rst      (rst),
    .step     (advance),
    .rx_byte  (stage_byte),
    .res_next (res_next)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign frame_ok          = res.frame_ok;
  assign error_code        = res.error_code;
  assign frame_control     = res.frame_control;
  assign frame_command     = res.frame_command;
  assign pulse_rate        = res.pulse_rate;
  assign pulse_rate_valid  = res.pulse_rate_valid;
  assign resp_rate         = res.resp_rate;
  assign resp_rate_valid   = res.resp_rate_valid;
  assign resp_status       = res.resp_status;
  assign resp_status_valid = res.resp_status_valid;
  assign good_frames       = res.good_frames;
  assign bad_frames        = res.bad_frames;

  a_stall_only_on_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> stage_valid && out_valid && !out_ready)
    else $error("input stalled while the pipeline could move");

  a_ok_excludes_error: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(frame_ok && error_code != vsfp_pkg::ERR_NONE))
    else $error("result flags both a good frame and an error");

  a_error_code_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> error_code == vsfp_pkg::ERR_NONE ||
                  error_code == vsfp_pkg::ERR_LENGTH ||
                  error_code == vsfp_pkg::ERR_CHECKSUM ||
                  error_code == vsfp_pkg::ERR_TAIL0 ||
                  error_code == vsfp_pkg::ERR_TAIL1)
    else $error("error code outside the defined set");

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int PAYLOAD_LIMIT = 64;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_BYTES  = 530;

  // ways a generated frame can be broken
  typedef enum int {
    FLAW_NONE,
    FLAW_HDR1,
    FLAW_SUM,
    FLAW_TAIL0,
    FLAW_TAIL1
  } frame_flaw_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        frame_ok;
  logic [2:0]  error_code;
  logic [7:0]  frame_control;
  logic [7:0]  frame_command;
  logic [7:0]  pulse_rate;
  logic        pulse_rate_valid;
  logic [7:0]  resp_rate;
  logic        resp_rate_valid;
  logic [7:0]  resp_status;
  logic        resp_status_valid;
  logic [31:0] good_frames;
  logic [31:0] bad_frames;

  vital_sign_frame_parser_unit #(.MAX_PAYLOAD(PAYLOAD_LIMIT)) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .frame_ok(frame_ok), .error_code(error_code),
    .frame_control(frame_control), .frame_command(frame_command),
    .pulse_rate(pulse_rate), .pulse_rate_valid(pulse_rate_valid),
    .resp_rate(resp_rate), .resp_rate_valid(resp_rate_valid),
    .resp_status(resp_status), .resp_status_valid(resp_status_valid),
    .good_frames(good_frames), .bad_frames(bad_frames)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // traffic shaping for the sender and the receiver, and run counters
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  int rx_hold_cycles = 0;
  int bytes_sent = 0;
  int mismatches = 0;
  int cycles = 0;

  // parser state as the predictor sees it
  vsfp_pkg::phase_t frame_phase = vsfp_pkg::PH_HDR0;
  logic [7:0]  ctrl_seen = '0;
  logic [7:0]  cmd_seen = '0;
  logic [15:0] frame_len = '0;
  int          data_count = 0;
  logic [7:0]  first_data = '0;
  logic [7:0]  sum_acc = '0;
  logic [31:0] good_count = '0;
  logic [31:0] bad_count = '0;
  logic [7:0]  heart_val = '0;
  logic        heart_seen = 1'b0;
  logic [7:0]  breath_val = '0;
  logic        breath_seen = 1'b0;
  logic [7:0]  breath_mode_val = '0;
  logic        breath_mode_seen = 1'b0;

  // output words still owed by the block, oldest first
  vsfp_pkg::result_t words_due[$];

  task automatic restart_search();
    frame_phase = vsfp_pkg::PH_HDR0;
    frame_len = '0;
    data_count = 0;
    sum_acc = '0;
  endtask

  // one parse step per accepted byte, queues the word it must produce
  task automatic advance_parser(input logic [7:0] b);
    vsfp_pkg::result_t   w;
    logic                ok;
    vsfp_pkg::err_code_t err;
    ok = 1'b0;
    err = vsfp_pkg::ERR_NONE;
    case (frame_phase)
      vsfp_pkg::PH_HDR0: if (b == vsfp_pkg::HDR0) begin
        sum_acc = b;
        frame_phase = vsfp_pkg::PH_HDR1;
      end
      vsfp_pkg::PH_HDR1: if (b == vsfp_pkg::HDR1) begin
        sum_acc = sum_acc + b;
        frame_phase = vsfp_pkg::PH_CTRL;
      end else begin
        restart_search();
        // a fresh sync byte re-arms at once
        if (b == vsfp_pkg::HDR0) begin
          sum_acc = b;
          frame_phase = vsfp_pkg::PH_HDR1;
        end
      end
      vsfp_pkg::PH_CTRL: begin
        ctrl_seen = b;
        sum_acc = sum_acc + b;
        frame_phase = vsfp_pkg::PH_CMD;
      end
      vsfp_pkg::PH_CMD: begin
        cmd_seen = b;
        sum_acc = sum_acc + b;
        frame_phase = vsfp_pkg::PH_LENH;
      end
      vsfp_pkg::PH_LENH: begin
        frame_len = {b, 8'h00};
        sum_acc = sum_acc + b;
        frame_phase = vsfp_pkg::PH_LENL;
      end
      vsfp_pkg::PH_LENL: begin
        frame_len = {frame_len[15:8], b};
        sum_acc = sum_acc + b;
        if (frame_len > PAYLOAD_LIMIT) begin
          err = vsfp_pkg::ERR_LENGTH;
        end else begin
          data_count = 0;
          frame_phase = (frame_len != 0) ? vsfp_pkg::PH_DATA : vsfp_pkg::PH_SUM;
        end
      end
      vsfp_pkg::PH_DATA: begin
        if (data_count == 0) first_data = b;
        data_count++;
        sum_acc = sum_acc + b;
        if (data_count >= frame_len) frame_phase = vsfp_pkg::PH_SUM;
      end
      vsfp_pkg::PH_SUM: begin
        if (b == sum_acc) frame_phase = vsfp_pkg::PH_TAIL0;
        else err = vsfp_pkg::ERR_CHECKSUM;
      end
      vsfp_pkg::PH_TAIL0: begin
        if (b == vsfp_pkg::TAIL0) frame_phase = vsfp_pkg::PH_TAIL1;
        else err = vsfp_pkg::ERR_TAIL0;
      end
      vsfp_pkg::PH_TAIL1: begin
        if (b == vsfp_pkg::TAIL1) begin
          ok = 1'b1;
          good_count++;
          // readings come only from single-byte frames
          if (frame_len == 1) begin
            if (ctrl_seen == vsfp_pkg::CTRL_HEART &&
                cmd_seen == vsfp_pkg::CMD_RATE) begin
              heart_val = first_data;
              heart_seen = 1'b1;
            end else if (ctrl_seen == vsfp_pkg::CTRL_BREATH &&
                         cmd_seen == vsfp_pkg::CMD_RATE) begin
              breath_val = first_data;
              breath_seen = 1'b1;
            end else if (ctrl_seen == vsfp_pkg::CTRL_BREATH &&
                         cmd_seen == vsfp_pkg::CMD_STATE) begin
              breath_mode_val = first_data;
              breath_mode_seen = 1'b1;
            end
          end
        end else begin
          err = vsfp_pkg::ERR_TAIL1;
        end
        restart_search();
      end
      default: restart_search();
    endcase
    if (err != vsfp_pkg::ERR_NONE) begin
      bad_count++;
      restart_search();
    end
    w.frame_ok = ok;
    w.error_code = err;
    w.frame_control = ctrl_seen;
    w.frame_command = cmd_seen;
    w.pulse_rate = heart_val;
    w.pulse_rate_valid = heart_seen;
    w.resp_rate = breath_val;
    w.resp_rate_valid = breath_seen;
    w.resp_status = breath_mode_val;
    w.resp_status_valid = breath_mode_seen;
    w.good_frames = good_count;
    w.bad_frames = bad_count;
    words_due.push_back(w);
  endtask

  // called at a falling edge, returns at the falling edge after the accept
  task automatic send_byte(input logic [7:0] b);
    if (tx_idle_on) begin
      while ($urandom_range(99) < 34) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    advance_parser(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  // sender pause until every owed word is out
  task automatic wait_words_drained();
    in_valid <= 1'b0;
    while (words_due.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [7:0] other_than(input logic [7:0] x);
    return x + 8'($urandom_range(1, 255));
  endfunction

  // one frame; data after the first byte is random
  task automatic send_frame(input logic [7:0] ctrl, input logic [7:0] cmd,
                            input logic [15:0] len, input logic [7:0] data0,
                            input frame_flaw_t flaw);
    logic [7:0] sum;
    logic [7:0] b;
    send_byte(vsfp_pkg::HDR0);
    if (flaw == FLAW_HDR1) begin
      send_byte(other_than(vsfp_pkg::HDR1));
      return;
    end
    sum = vsfp_pkg::HDR0 + vsfp_pkg::HDR1 + ctrl + cmd + len[15:8] + len[7:0];
    send_byte(vsfp_pkg::HDR1);
    send_byte(ctrl);
    send_byte(cmd);
    send_byte(len[15:8]);
    send_byte(len[7:0]);
    // oversize length aborts right here
    if (len > PAYLOAD_LIMIT) return;
    for (int i = 0; i < len; i++) begin
      b = (i == 0) ? data0 : 8'($urandom);
      sum = sum + b;
      send_byte(b);
    end
    send_byte((flaw == FLAW_SUM) ? other_than(sum) : sum);
    send_byte((flaw == FLAW_TAIL0) ? other_than(vsfp_pkg::TAIL0) : vsfp_pkg::TAIL0);
    send_byte((flaw == FLAW_TAIL1) ? other_than(vsfp_pkg::TAIL1) : vsfp_pkg::TAIL1);
  endtask

  // receiver: random stalls, or a long hold-off on request
  initial begin : rx_side
    forever begin
      @(negedge clk);
      if (rx_hold_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (rx_hold_cycles) @(negedge clk);
        rx_hold_cycles = 0;
      end else begin
        out_ready <= !rx_idle_on || ($urandom_range(99) >= 34);
      end
    end
  end

  // compare each delivered word with the oldest owed one
  always @(posedge clk) begin
    vsfp_pkg::result_t exp_w;
    if (!rst && out_valid && out_ready) begin
      if (words_due.size() == 0) begin
        $error("output word with nothing due");
        mismatches++;
      end else begin
        exp_w = words_due.pop_front();
        if (frame_ok !== exp_w.frame_ok) begin
          $error("frame_ok exp %0d got %0d", exp_w.frame_ok, frame_ok);
          mismatches++;
        end
        if (error_code !== exp_w.error_code) begin
          $error("error_code exp %0d got %0d", exp_w.error_code, error_code);
          mismatches++;
        end
        if (frame_control !== exp_w.frame_control) begin
          $error("frame_control exp %h got %h", exp_w.frame_control, frame_control);
          mismatches++;
        end
        if (frame_command !== exp_w.frame_command) begin
          $error("frame_command exp %h got %h", exp_w.frame_command, frame_command);
          mismatches++;
        end
        if (pulse_rate !== exp_w.pulse_rate) begin
          $error("pulse_rate exp %h got %h", exp_w.pulse_rate, pulse_rate);
          mismatches++;
        end
        if (pulse_rate_valid !== exp_w.pulse_rate_valid) begin
          $error("pulse_rate_valid exp %0d got %0d", exp_w.pulse_rate_valid,
                 pulse_rate_valid);
          mismatches++;
        end
        if (resp_rate !== exp_w.resp_rate) begin
          $error("resp_rate exp %h got %h", exp_w.resp_rate, resp_rate);
          mismatches++;
        end
        if (resp_rate_valid !== exp_w.resp_rate_valid) begin
          $error("resp_rate_valid exp %0d got %0d", exp_w.resp_rate_valid,
                 resp_rate_valid);
          mismatches++;
        end
        if (resp_status !== exp_w.resp_status) begin
          $error("resp_status exp %h got %h", exp_w.resp_status, resp_status);
          mismatches++;
        end
        if (resp_status_valid !== exp_w.resp_status_valid) begin
          $error("resp_status_valid exp %0d got %0d", exp_w.resp_status_valid,
                 resp_status_valid);
          mismatches++;
        end
        if (good_frames !== exp_w.good_frames) begin
          $error("good_frames exp %0d got %0d", exp_w.good_frames, good_frames);
          mismatches++;
        end
        if (bad_frames !== exp_w.bad_frames) begin
          $error("bad_frames exp %0d got %0d", exp_w.bad_frames, bad_frames);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // good frames: all three readings, other codes, wrong size, empty frame, full-length frame
  task automatic test_reading_frames();
    send_frame(vsfp_pkg::CTRL_HEART, vsfp_pkg::CMD_RATE, 16'd1, 8'hFF, FLAW_NONE);
    send_frame(vsfp_pkg::CTRL_BREATH, vsfp_pkg::CMD_RATE, 16'd1, 8'h00, FLAW_NONE);
    send_frame(vsfp_pkg::CTRL_BREATH, vsfp_pkg::CMD_STATE, 16'd1, 8'hA5, FLAW_NONE);
    send_frame(8'h00, 8'hFF, 16'd1, 8'h5A, FLAW_NONE);
    send_frame(vsfp_pkg::CTRL_HEART, vsfp_pkg::CMD_RATE, 16'd2, 8'h11, FLAW_NONE);
    send_frame(8'hFF, 8'h00, 16'd0, 8'h00, FLAW_NONE);
    send_frame(vsfp_pkg::CTRL_BREATH, vsfp_pkg::CMD_RATE, 16'(PAYLOAD_LIMIT), 8'h3C,
               FLAW_NONE);
  endtask

  // length, checksum and tail errors, bad sync, re-arm on a repeated 0x53
  task automatic test_frame_errors();
    send_frame(vsfp_pkg::CTRL_HEART, vsfp_pkg::CMD_RATE, 16'(PAYLOAD_LIMIT + 1), 8'h00,
               FLAW_NONE);
    send_frame(vsfp_pkg::CTRL_HEART, vsfp_pkg::CMD_RATE, 16'hFFFF, 8'h00, FLAW_NONE);
    send_frame(vsfp_pkg::CTRL_HEART, vsfp_pkg::CMD_RATE, 16'h0100, 8'h00, FLAW_NONE);
    send_frame(vsfp_pkg::CTRL_HEART, vsfp_pkg::CMD_RATE, 16'd1, 8'h40, FLAW_SUM);
    send_frame(vsfp_pkg::CTRL_BREATH, vsfp_pkg::CMD_RATE, 16'd1, 8'h41, FLAW_TAIL0);
    send_frame(vsfp_pkg::CTRL_BREATH, vsfp_pkg::CMD_STATE, 16'd1, 8'h42, FLAW_TAIL1);
    send_frame(vsfp_pkg::CTRL_HEART, vsfp_pkg::CMD_RATE, 16'd1, 8'h43, FLAW_HDR1);
    send_byte(vsfp_pkg::HDR0);
    send_frame(vsfp_pkg::CTRL_HEART, vsfp_pkg::CMD_RATE, 16'd1, 8'h48, FLAW_NONE);
  endtask

  // long receiver hold-off while the sender keeps offering bytes
  task automatic test_backpressure();
    tx_idle_on = 1'b0;
    rx_hold_cycles = 60;
    send_frame(vsfp_pkg::CTRL_BREATH, vsfp_pkg::CMD_STATE, 16'd20, 8'h07, FLAW_NONE);
    wait_words_drained();
    tx_idle_on = 1'b1;
  endtask

  // mostly well-formed frames with random content, some noise and damage
  task automatic test_random_frames();
    int          start;
    int          n;
    logic [7:0]  ctrl;
    logic [7:0]  cmd;
    logic [15:0] len;
    frame_flaw_t flaw;
    start = bytes_sent;
    while (bytes_sent - start < RANDOM_BYTES) begin
      n = bytes_sent - start;
      // a quiet stretch with no idling on either side
      tx_idle_on = !(n >= 250 && n < 400);
      rx_idle_on = tx_idle_on;
      if ($urandom_range(99) < 10) begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
      end else begin
        case ($urandom_range(3))
          0: ctrl = vsfp_pkg::CTRL_HEART;
          1, 2: ctrl = vsfp_pkg::CTRL_BREATH;
          default: ctrl = 8'($urandom);
        endcase
        case ($urandom_range(3))
          0, 1: cmd = vsfp_pkg::CMD_RATE;
          2: cmd = vsfp_pkg::CMD_STATE;
          default: cmd = 8'($urandom);
        endcase
        n = $urandom_range(99);
        if (n < 60) len = 16'd1;
        else if (n < 85) len = 16'($urandom_range(0, 8));
        else if (n < 93) len = 16'($urandom_range(9, PAYLOAD_LIMIT));
        else len = 16'($urandom_range(PAYLOAD_LIMIT + 1, 65535));
        flaw = ($urandom_range(99) < 80) ? FLAW_NONE
                                          : frame_flaw_t'($urandom_range(1, 4));
        send_frame(ctrl, cmd, len, 8'($urandom), flaw);
      end
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    test_reading_frames();
    test_frame_errors();
    test_backpressure();
    test_random_frames();
    wait_words_drained();
    // let the clock run on so any stray word still shows up
    repeat (10) @(posedge clk);
    if (mismatches == 0 && words_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
